/* hw/rtl/vsv_pkg.sv */
// ----------------------------------------------------------------------------
// vsv_pkg
// Types and constants of the smoothed vortex segment velocity pipeline.
// ----------------------------------------------------------------------------
package vsv_pkg;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] seg_start_x;
    logic signed [31:0] seg_start_y;
    logic signed [31:0] seg_end_x;
    logic signed [31:0] seg_end_y;
  } vsv_in_t;

  typedef struct packed {
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic               saturated;
  } vsv_out_t;

  // one endpoint's contribution, magnitude capped at 2^40
  typedef struct packed {
    logic signed [41:0] cx;
    logic signed [41:0] cy;
    logic               clip;
  } vsv_contrib_t;

  localparam int RAD_W  = 31;
  localparam int EPS2_W = 62;
  localparam int R2_W   = 63;
  localparam int MAG_W  = 31;
  localparam int PC_W   = 61;
  localparam int K_W    = 33;
  localparam int S_W    = 30;
  localparam int QB     = 41;

  // 1/(2*pi) in Q32
  localparam logic [29:0] INV_2PI = 30'd683565276;
  localparam logic [K_W-1:0] K_ONE = K_W'(64'd1 << 30);
  localparam logic [QB-1:0] Q_LIMIT = QB'(64'd1 << 40);

  localparam int LAT_K    = 63;   // s2 divide, isqrt, polynomial
  localparam int LAT_Q    = 43;   // quotient divide
  localparam int LAT_EP   = 4 + LAT_K + 2 + LAT_Q + 1;
  localparam int LAT_PIPE = LAT_EP + 1;

endpackage

/* hw/rtl/vsv_smooth.sv */
// ----------------------------------------------------------------------------
// vsv_smooth
// Smoothing factor K in Q30: s2 = r2/eps^2, s = sqrt(s2), polynomial in s.
// ----------------------------------------------------------------------------
module vsv_smooth (
  input  logic                         clk,
  input  logic                         en,
  input  logic [vsv_pkg::R2_W-1:0]     r2,
  input  logic [vsv_pkg::EPS2_W-1:0]   eps_sq,
  input  logic                         smooth,
  output logic [vsv_pkg::K_W-1:0]      k
);

  logic [vsv_pkg::R2_W-1:0] drem_r [0:29];
  logic [vsv_pkg::S_W-1:0]  dq_r   [0:29];
  logic                     dsm_r  [0:29];

  logic [59:0]              sx_r   [0:29];
  logic [59:0]              sres_r [0:29];
  logic [vsv_pkg::S_W-1:0]  ss2_r  [0:29];
  logic                     ssm_r  [0:29];

  genvar gi;

  // restoring divide, one quotient bit per stage
  for (gi = 0; gi < 30; gi++) begin : g_div
    logic [vsv_pkg::R2_W-1:0] rem_in;
    logic [vsv_pkg::S_W-1:0]  q_in;
    logic                     sm_in;
    logic [63:0]              rem2;
    logic [63:0]              den;
    logic                     ge;
    if (gi == 0) begin : g_first
      assign rem_in = r2;
      assign q_in   = '0;
      assign sm_in  = smooth;
    end else begin : g_next
      assign rem_in = drem_r[gi-1];
      assign q_in   = dq_r[gi-1];
      assign sm_in  = dsm_r[gi-1];
    end
    assign rem2 = {rem_in, 1'b0};
    assign den  = {2'b00, eps_sq};
    assign ge   = rem2 >= den;
    always_ff @(posedge clk) begin
      if (en) begin
        drem_r[gi] <= ge ? 63'(rem2 - den) : rem2[62:0];
        dq_r[gi]   <= {q_in[28:0], ge};
        dsm_r[gi]  <= sm_in;
      end
    end
  end

  // digit-by-digit square root of s2 << 30
  for (gi = 0; gi < 30; gi++) begin : g_sqrt
    localparam logic [59:0] BIT = 60'(1) << (58 - 2 * gi);
    logic [59:0]             x_in;
    logic [59:0]             res_in;
    logic [59:0]             t;
    logic [vsv_pkg::S_W-1:0] s2_in;
    logic                    sm_in;
    if (gi == 0) begin : g_first
      assign x_in   = {dq_r[29], 30'b0};
      assign res_in = '0;
      assign s2_in  = dq_r[29];
      assign sm_in  = dsm_r[29];
    end else begin : g_next
      assign x_in   = sx_r[gi-1];
      assign res_in = sres_r[gi-1];
      assign s2_in  = ss2_r[gi-1];
      assign sm_in  = ssm_r[gi-1];
    end
    assign t = res_in + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if (x_in >= t) begin
          sx_r[gi]   <= x_in - t;
          sres_r[gi] <= (res_in >> 1) + BIT;
        end else begin
          sx_r[gi]   <= x_in;
          sres_r[gi] <= res_in >> 1;
        end
        ss2_r[gi] <= s2_in;
        ssm_r[gi] <= sm_in;
      end
    end
  end

  logic [vsv_pkg::S_W-1:0] s_p1_r, s2_p1_r, s4_p1_r;
  logic                    sm_p1_r;
  logic [vsv_pkg::S_W-1:0] s5_p2_r;
  logic [32:0]             p3_p2_r;
  logic                    sm_p2_r;
  logic [vsv_pkg::K_W-1:0] k_r;

  logic [59:0] s4_full;
  logic [59:0] s5_full;
  logic [37:0] p_full;
  logic [62:0] k_full;

  assign s4_full = ss2_r[29] * ss2_r[29];
  assign s5_full = s4_p1_r * s_p1_r;
  assign p_full  = (38'd63 << 30) + 38'd35 * 38'(s4_p1_r) - 38'd90 * 38'(s2_p1_r);
  assign k_full  = 63'(s5_p2_r) * 63'(p3_p2_r);

  always_ff @(posedge clk) begin
    if (en) begin
      s_p1_r  <= sres_r[29][29:0];
      s2_p1_r <= ss2_r[29];
      s4_p1_r <= 30'(s4_full >> 30);
      sm_p1_r <= ssm_r[29];
      s5_p2_r <= 30'(s5_full >> 30);
      p3_p2_r <= p_full[35:3];
      sm_p2_r <= sm_p1_r;
      k_r     <= sm_p2_r ? 33'(k_full >> 30) : vsv_pkg::K_ONE;
    end
  end

  assign k = k_r;

endmodule

/* hw/rtl/vsv_qdiv.sv */
// ----------------------------------------------------------------------------
// vsv_qdiv
// Pipelined restoring divide, quotient capped at 2^40 with overflow flag.
// ----------------------------------------------------------------------------
module vsv_qdiv #(
  parameter int NW = 64
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [NW-1:0]              num,
  input  logic [vsv_pkg::R2_W-1:0]   den,
  output logic [vsv_pkg::QB-1:0]     q,
  output logic                       over
);

  localparam int QBITS = vsv_pkg::QB;

  logic [vsv_pkg::R2_W-1:0] rem_r [0:QBITS];
  logic [vsv_pkg::R2_W-1:0] den_r [0:QBITS];
  logic [QBITS-1:0]         lo_r  [0:QBITS];
  logic [QBITS-1:0]         q_r   [0:QBITS];
  logic                     ov_r  [0:QBITS];
  logic [QBITS-1:0]         qo_r;
  logic                     ovo_r;

  logic [vsv_pkg::R2_W-1:0] hi;

  assign hi = vsv_pkg::R2_W'(num[NW-1:QBITS]);

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= hi;
      den_r[0] <= den;
      lo_r[0]  <= num[QBITS-1:0];
      q_r[0]   <= '0;
      ov_r[0]  <= hi >= den;
    end
  end

  genvar gi;
  for (gi = 0; gi < QBITS; gi++) begin : g_step
    logic [63:0] rem2;
    logic [63:0] dext;
    logic        ge;
    assign rem2 = {rem_r[gi], lo_r[gi][QBITS-1]};
    assign dext = {1'b0, den_r[gi]};
    assign ge   = rem2 >= dext;
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[gi+1] <= ge ? 63'(rem2 - dext) : rem2[62:0];
        den_r[gi+1] <= den_r[gi];
        lo_r[gi+1]  <= {lo_r[gi][QBITS-2:0], 1'b0};
        q_r[gi+1]   <= {q_r[gi][QBITS-2:0], ge};
        ov_r[gi+1]  <= ov_r[gi];
      end
    end
  end

  logic ov_fin;
  assign ov_fin = ov_r[QBITS] || (q_r[QBITS] > vsv_pkg::Q_LIMIT);

  always_ff @(posedge clk) begin
    if (en) begin
      qo_r  <= ov_fin ? vsv_pkg::Q_LIMIT : q_r[QBITS];
      ovo_r <= ov_fin;
    end
  end

  assign q    = qo_r;
  assign over = ovo_r;

endmodule

/* hw/rtl/vsv_endpoint.sv */
// ----------------------------------------------------------------------------
// vsv_endpoint
// Velocity contribution of one segment endpoint at the field point.
// ----------------------------------------------------------------------------
module vsv_endpoint #(
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic signed [31:0]         px,
  input  logic signed [31:0]         py,
  input  logic signed [31:0]         ax,
  input  logic signed [31:0]         ay,
  input  logic [vsv_pkg::EPS2_W-1:0] eps_sq,
  output vsv_pkg::vsv_contrib_t      res
);

  localparam int NW  = 2 * FRAC_BITS + 32;
  localparam int SH0 = 62 - 2 * FRAC_BITS;

  typedef struct packed {
    logic [vsv_pkg::PC_W-1:0] pcx;
    logic [vsv_pkg::PC_W-1:0] pcy;
    logic [vsv_pkg::R2_W-1:0] r2;
    logic                     h;
    logic                     zero;
    logic                     nx;
    logic                     ny;
  } side_t;

  typedef struct packed {
    logic zero;
    logic nx;
    logic ny;
  } sgn_t;

  // E1: differences
  logic signed [32:0] dx_r, dy_r;
  always_ff @(posedge clk) begin
    if (en) begin
      dx_r <= {px[31], px} - {ax[31], ax};
      dy_r <= {py[31], py} - {ay[31], ay};
    end
  end

  // E2: magnitudes, far-point halving
  logic [32:0] ndx, ndy;
  logic [31:0] mx, my;
  logic        hv;
  logic [vsv_pkg::MAG_W-1:0] mxs_r, mys_r;
  logic h_e2_r, zero_e2_r, nx_e2_r, ny_e2_r;

  assign ndx = -dx_r;
  assign ndy = -dy_r;
  assign mx  = dx_r[32] ? ndx[31:0] : dx_r[31:0];
  assign my  = dy_r[32] ? ndy[31:0] : dy_r[31:0];
  assign hv  = mx[31] | my[31];

  always_ff @(posedge clk) begin
    if (en) begin
      mxs_r     <= hv ? mx[31:1] : mx[30:0];
      mys_r     <= hv ? my[31:1] : my[30:0];
      h_e2_r    <= hv;
      zero_e2_r <= (dx_r == '0) && (dy_r == '0);
      nx_e2_r   <= dx_r[32];
      ny_e2_r   <= dy_r[32];
    end
  end

  // E3: squares and scaled magnitudes
  logic [61:0] sqx_r, sqy_r;
  logic [vsv_pkg::PC_W-1:0] pcx_r, pcy_r;
  logic h_e3_r, zero_e3_r, nx_e3_r, ny_e3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sqx_r     <= 62'(mxs_r) * 62'(mxs_r);
      sqy_r     <= 62'(mys_r) * 62'(mys_r);
      pcx_r     <= 61'(mxs_r) * 61'(vsv_pkg::INV_2PI);
      pcy_r     <= 61'(mys_r) * 61'(vsv_pkg::INV_2PI);
      h_e3_r    <= h_e2_r;
      zero_e3_r <= zero_e2_r;
      nx_e3_r   <= nx_e2_r;
      ny_e3_r   <= ny_e2_r;
    end
  end

  // E4: r2 and core test
  logic [vsv_pkg::R2_W-1:0] r2_sum;
  side_t side_e4_r;
  logic  sm_e4_r;

  assign r2_sum = 63'(sqx_r) + 63'(sqy_r);

  always_ff @(posedge clk) begin
    if (en) begin
      side_e4_r.pcx  <= pcx_r;
      side_e4_r.pcy  <= pcy_r;
      side_e4_r.r2   <= r2_sum;
      side_e4_r.h    <= h_e3_r;
      side_e4_r.zero <= zero_e3_r;
      side_e4_r.nx   <= nx_e3_r;
      side_e4_r.ny   <= ny_e3_r;
      sm_e4_r        <= !h_e3_r && (r2_sum < {1'b0, eps_sq});
    end
  end

  logic [vsv_pkg::K_W-1:0] k;

  vsv_smooth u_smooth (
    .clk    (clk),
    .en     (en),
    .r2     (side_e4_r.r2),
    .eps_sq (eps_sq),
    .smooth (sm_e4_r),
    .k      (k)
  );

  side_t side_dl_r [0:vsv_pkg::LAT_K-1];
  always_ff @(posedge clk) begin
    if (en) begin
      side_dl_r[0] <= side_e4_r;
      for (int i = 1; i < vsv_pkg::LAT_K; i++) begin
        side_dl_r[i] <= side_dl_r[i-1];
      end
    end
  end

  side_t side_k;
  assign side_k = side_dl_r[vsv_pkg::LAT_K-1];

  // N1: partial products
  logic [63:0] plx_r, ply_r;
  logic [62:0] phx_r, phy_r;
  logic [vsv_pkg::R2_W-1:0] r2_n1_r;
  logic h_n1_r;
  sgn_t sg_n1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      plx_r   <= 64'(side_k.pcx[30:0]) * 64'(k);
      ply_r   <= 64'(side_k.pcy[30:0]) * 64'(k);
      phx_r   <= 63'(side_k.pcx[60:31]) * 63'(k);
      phy_r   <= 63'(side_k.pcy[60:31]) * 63'(k);
      r2_n1_r <= side_k.r2;
      h_n1_r  <= side_k.h;
      sg_n1_r <= '{zero: side_k.zero, nx: side_k.nx, ny: side_k.ny};
    end
  end

  // N2: sum and scale
  logic [93:0] prx, pry;
  logic [NW-1:0] numx_r, numy_r;
  logic [vsv_pkg::R2_W-1:0] r2_n2_r;
  sgn_t sg_n2_r;

  assign prx = {phx_r, 31'b0} + 94'(plx_r);
  assign pry = {phy_r, 31'b0} + 94'(ply_r);

  always_ff @(posedge clk) begin
    if (en) begin
      numx_r  <= h_n1_r ? NW'(prx >> (SH0 + 1)) : NW'(prx >> SH0);
      numy_r  <= h_n1_r ? NW'(pry >> (SH0 + 1)) : NW'(pry >> SH0);
      r2_n2_r <= r2_n1_r;
      sg_n2_r <= sg_n1_r;
    end
  end

  logic [vsv_pkg::QB-1:0] qx, qy;
  logic ovx, ovy;

  vsv_qdiv #(.NW(NW)) u_qdiv_y (
    .clk  (clk),
    .en   (en),
    .num  (numy_r),
    .den  (r2_n2_r),
    .q    (qy),
    .over (ovy)
  );

  vsv_qdiv #(.NW(NW)) u_qdiv_x (
    .clk  (clk),
    .en   (en),
    .num  (numx_r),
    .den  (r2_n2_r),
    .q    (qx),
    .over (ovx)
  );

  sgn_t sg_dl_r [0:vsv_pkg::LAT_Q-1];
  always_ff @(posedge clk) begin
    if (en) begin
      sg_dl_r[0] <= sg_n2_r;
      for (int i = 1; i < vsv_pkg::LAT_Q; i++) begin
        sg_dl_r[i] <= sg_dl_r[i-1];
      end
    end
  end

  // F: signs
  sgn_t sg_q;
  logic signed [41:0] qxs, qys;
  vsv_pkg::vsv_contrib_t res_r;

  assign sg_q = sg_dl_r[vsv_pkg::LAT_Q-1];
  assign qxs  = {1'b0, qx};
  assign qys  = {1'b0, qy};

  always_ff @(posedge clk) begin
    if (en) begin
      res_r.cx   <= sg_q.zero ? '0 : (sg_q.ny ? -qys : qys);
      res_r.cy   <= sg_q.zero ? '0 : (sg_q.nx ? qxs : -qxs);
      res_r.clip <= !sg_q.zero && (ovx || ovy);
    end
  end

  assign res = res_r;

endmodule

/* hw/rtl/vortex_segment_velocity_smoothed.sv */
// ----------------------------------------------------------------------------
// vortex_segment_velocity_smoothed
// Smoothed 2D velocity induced by a vortex segment at a field point.
//
//   channel  ports                      dir   word
//   input    in_valid/in_stall/in_data  in    vsv_in_t
//   result   out_valid/out_stall/out_data out vsv_out_t
//   config   cfg_wr_en/cfg_wr_data      in    smoothing radius, unsigned Q15.16
//
// One word per cycle unless a stalled result holds the pipe.
// Latency is set by the bit-serial stages: 30 for r2/eps^2, 30 for sqrt,
// 41 for the velocity quotient, plus product and combine stages.
// Reset clears the valid bits and loads the radius with 1.0.
// A stalled result holds the pipe only once its last stage is occupied.
// ----------------------------------------------------------------------------
module vortex_segment_velocity_smoothed #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  vsv_pkg::vsv_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output vsv_pkg::vsv_out_t             out_data,
  input  logic                          cfg_wr_en,
  input  logic [vsv_pkg::RAD_W-1:0]     cfg_wr_data
);

  logic [vsv_pkg::RAD_W-1:0]  radius_r;
  logic [vsv_pkg::EPS2_W-1:0] eps_sq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= vsv_pkg::RAD_W'(32'd65536);
    end else if (cfg_wr_en) begin
      radius_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    eps_sq_r <= 62'(radius_r) * 62'(radius_r);
  end

  logic vld_r [0:vsv_pkg::LAT_PIPE-1];
  logic last_valid;
  logic pipe_adv;
  logic out_valid_r;
  vsv_pkg::vsv_out_t out_r;
  vsv_pkg::vsv_out_t last_r;

  assign last_valid = vld_r[vsv_pkg::LAT_PIPE-1];
  assign pipe_adv   = !last_valid || !out_valid_r || !out_stall;
  assign in_stall   = !pipe_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < vsv_pkg::LAT_PIPE; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (pipe_adv) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < vsv_pkg::LAT_PIPE; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  vsv_pkg::vsv_contrib_t ca, cb;

  vsv_endpoint #(.FRAC_BITS(FRAC_BITS)) u_ep_start (
    .clk    (clk),
    .en     (pipe_adv),
    .px     (in_data.point_x),
    .py     (in_data.point_y),
    .ax     (in_data.seg_start_x),
    .ay     (in_data.seg_start_y),
    .eps_sq (eps_sq_r),
    .res    (ca)
  );

  vsv_endpoint #(.FRAC_BITS(FRAC_BITS)) u_ep_end (
    .clk    (clk),
    .en     (pipe_adv),
    .px     (in_data.point_x),
    .py     (in_data.point_y),
    .ax     (in_data.seg_end_x),
    .ay     (in_data.seg_end_y),
    .eps_sq (eps_sq_r),
    .res    (cb)
  );

  localparam logic signed [42:0] VMAX = 43'sd2147483647;
  localparam logic signed [42:0] VMIN = -43'sd2147483648;

  logic signed [42:0] dvx, dvy;
  logic hix, lox, hiy, loy;

  assign dvx = {ca.cx[41], ca.cx} - {cb.cx[41], cb.cx};
  assign dvy = {ca.cy[41], ca.cy} - {cb.cy[41], cb.cy};
  assign hix = dvx > VMAX;
  assign lox = dvx < VMIN;
  assign hiy = dvy > VMAX;
  assign loy = dvy < VMIN;

  always_ff @(posedge clk) begin
    if (pipe_adv) begin
      last_r.vel_x     <= hix ? VMAX[31:0] : (lox ? VMIN[31:0] : dvx[31:0]);
      last_r.vel_y     <= hiy ? VMAX[31:0] : (loy ? VMIN[31:0] : dvy[31:0]);
      last_r.saturated <= ca.clip || cb.clip || hix || lox || hiy || loy;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      out_valid_r <= last_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || !out_stall) begin
      out_r <= last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* hw/rtl/vsv_chk.sv */
// ----------------------------------------------------------------------------
// vsv_chk
// Port-level checks of the velocity pipeline handshake.
// ----------------------------------------------------------------------------
module vsv_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input vsv_pkg::vsv_out_t out_data
);

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid)
    else $error("input word dropped while stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("stalled result word changed");

  a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  a_reset_clear: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind vortex_segment_velocity_smoothed vsv_chk u_vsv_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the smoothed vortex segment velocity pipeline.
// Words go in under random gaps and leave under random stalls, but for a quiet
// tail. A velocity predictor computes each expected word when its input word
// is taken. Several smoothing radii are swept, among them 1 and the largest.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int LIMIT_CYC = 600000;

  class velocity_board;
    vsv_pkg::vsv_out_t expected_q[$];
    int errors;
    logic [30:0] radius;

    function new();
      errors = 0;
      radius = 31'd65536;
    endfunction

    function longint unsigned root64(longint unsigned x);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= res + b) begin
          x = x - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    function void contrib(longint px, longint py, longint ax, longint ay,
                          output longint cx, output longint cy, inout bit clip);
      longint dx, dy;
      longint unsigned mx, my, r2, k, eps2, s2, s, s4, s5, pc, qx, qy;
      logic [127:0] num, t;
      int h;
      dx = px - ax;
      dy = py - ay;
      mx = dx < 0 ? -dx : dx;
      my = dy < 0 ? -dy : dy;
      cx = 0;
      cy = 0;
      if (mx == 0 && my == 0) return;
      h = ((mx >> 31) != 0 || (my >> 31) != 0) ? 1 : 0;
      mx = mx >> h;
      my = my >> h;
      r2 = mx * mx + my * my;
      k = 64'd1 << 30;
      eps2 = 64'(radius) * 64'(radius);
      if (h == 0 && r2 < eps2) begin
        num = 128'(r2) << 30;
        t = num / 128'(eps2);
        s2 = (t > 128'(k)) ? k : t[63:0];
        s = root64(s2 << 30);
        s4 = (s2 * s2) >> 30;
        s5 = (s4 * s) >> 30;
        pc = 63 * (64'd1 << 30) - 90 * s2 + 35 * s4;
        k = (s5 * (pc >> 3)) >> 30;
      end
      t = ((128'(my * 64'd683565276) * 128'(k)) >> (30 + h)) / 128'(r2);
      if (t > (128'd1 << 40)) begin
        t = 128'd1 << 40;
        clip = 1;
      end
      qy = t[63:0];
      t = ((128'(mx * 64'd683565276) * 128'(k)) >> (30 + h)) / 128'(r2);
      if (t > (128'd1 << 40)) begin
        t = 128'd1 << 40;
        clip = 1;
      end
      qx = t[63:0];
      cx = dy < 0 ? -longint'(qy) : longint'(qy);
      cy = dx < 0 ? longint'(qx) : -longint'(qx);
    endfunction

    function logic [31:0] clamp32(longint v, inout bit clip);
      if (v > 64'sd2147483647) begin
        v = 64'sd2147483647;
        clip = 1;
      end
      if (v < -64'sd2147483648) begin
        v = -64'sd2147483648;
        clip = 1;
      end
      return v[31:0];
    endfunction

    function void note_input(vsv_pkg::vsv_in_t w);
      longint ax, ay, bx, by;
      bit clip;
      vsv_pkg::vsv_out_t r;
      clip = 0;
      contrib(longint'(w.point_x), longint'(w.point_y), longint'(w.seg_start_x),
              longint'(w.seg_start_y), ax, ay, clip);
      contrib(longint'(w.point_x), longint'(w.point_y), longint'(w.seg_end_x),
              longint'(w.seg_end_y), bx, by, clip);
      r.vel_x = clamp32(ax - bx, clip);
      r.vel_y = clamp32(ay - by, clip);
      r.saturated = clip;
      expected_q.push_back(r);
    endfunction

    function void check_result(vsv_pkg::vsv_out_t got);
      vsv_pkg::vsv_out_t exp_w;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word %h", got);
        return;
      end
      exp_w = expected_q.pop_front();
      if (got.vel_x !== exp_w.vel_x || got.vel_y !== exp_w.vel_y ||
          got.saturated !== exp_w.saturated) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp vx=%h vy=%h sat=%b, got vx=%h vy=%h sat=%b",
                   exp_w.vel_x, exp_w.vel_y, exp_w.saturated,
                   got.vel_x, got.vel_y, got.saturated);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  vsv_pkg::vsv_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 0;
  vsv_pkg::vsv_out_t out_data;
  logic cfg_wr_en = 0;
  logic [vsv_pkg::RAD_W-1:0] cfg_wr_data = '0;

  velocity_board board = new();
  bit quiet = 0;
  int cyc = 0;

  always #2 clk = ~clk;

  vortex_segment_velocity_smoothed i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_result(out_data);
  end

  always @(posedge clk) begin
    cyc++;
    if (cyc > LIMIT_CYC) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (quiet || $urandom_range(0, 2) != 0) begin
        out_stall <= 0;
        repeat ($urandom_range(0, 30)) @(posedge clk);
      end else begin
        out_stall <= 1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_stall <= 0;
      end
    end
  end

  task automatic send_word(vsv_pkg::vsv_in_t w);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_input(w);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (board.expected_q.size() != 0) @(posedge clk);
    repeat (vsv_pkg::LAT_PIPE + 8) @(posedge clk);
  endtask

  task automatic set_radius(logic [30:0] r);
    drain();
    cfg_wr_en <= 1;
    cfg_wr_data <= r;
    @(posedge clk);
    cfg_wr_en <= 0;
    board.radius = r;
  endtask

  function automatic logic [31:0] near(logic [31:0] base);
    logic [31:0] d;
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return base;
      default: begin
        d = $urandom & ((32'd1 << $urandom_range(0, 24)) - 1);
        return $urandom_range(0, 1) ? base + d : base - d;
      end
    endcase
  endfunction

  function automatic vsv_pkg::vsv_in_t rand_word();
    vsv_pkg::vsv_in_t w;
    w.point_x = $urandom;
    w.point_y = $urandom;
    w.seg_start_x = near(w.point_x);
    w.seg_start_y = near(w.point_y);
    w.seg_end_x = near(w.point_x);
    w.seg_end_y = near(w.point_y);
    return w;
  endfunction

  task automatic directed();
    logic [31:0] mn, mx;
    mn = 32'h8000_0000;
    mx = 32'h7fff_ffff;
    send_word('0);
    send_word('{mx, mx, mn, mn, mn, mx});
    send_word('{mn, mn, mx, mx, mx, mn});
    send_word('{mn, mx, mx, mn, mn, mx});
    send_word('{32'd100, 32'd200, 32'd100, 32'd200, 32'd101, 32'd200});
    send_word('{32'd0, 32'd0, 32'd1, 32'd0, 32'd0, 32'd1});
    send_word('{32'd0, 32'd0, 32'd32768, 32'd0, 32'd0, 32'hffff8000});
    send_word('{32'd0, 32'd0, 32'd65535, 32'd0, 32'd65536, 32'd0});
    send_word('{32'd0, 32'd0, 32'd65537, 32'd1, 32'd46341, 32'd46341});
    send_word('{32'd5, 32'd7, 32'd5, 32'd7, 32'd5, 32'd7});
    send_word('{mx, 32'd0, mn, 32'd0, 32'd0, 32'd0});
    send_word('{32'd0, mn, 32'd0, mx, 32'd3, 32'd3});
    send_word('{32'hffffffff, 32'd0, 32'd0, 32'd0, 32'd0, 32'd1});
  endtask

  initial begin
    logic [30:0] radii[5];
    radii = '{31'd65536, 31'd1, 31'h7fffffff, 31'd262144, 31'd0};
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    directed();
    foreach (radii[p]) begin
      if (p != 0) set_radius(p == 4 ? 31'($urandom_range(1, 32'h7fffffff)) : radii[p]);
      if (p == 1) directed();
      for (int i = 0; i < 380; i++) begin
        if (p == 2 && i == 190) drain();
        if (p == 4 && i == 250) quiet = 1;
        send_word(rand_word());
      end
    end
    drain();
    if (board.errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule

/* sim.f */
hw/rtl/vsv_pkg.sv
hw/rtl/vsv_smooth.sv
hw/rtl/vsv_qdiv.sv
hw/rtl/vsv_endpoint.sv
hw/rtl/vortex_segment_velocity_smoothed.sv
hw/rtl/vsv_chk.sv
tb/tb_top.sv
